### src/bls_pkg.sv
package bls_pkg;

  // field widths of one command and one result
  localparam int CMD_W    = 3;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // number of stack entries, bounded by what the count field can carry
  localparam int DEPTH = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd3;

  // capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;  // accept the request: update the stack, start the read
    logic load;  // capture the result into the response register
  } ctrl_cmd_t;

endpackage

### src/bls_ctrl.sv
module bls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bls_pkg::ctrl_cmd_t cmd
);
  import bls_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_free;

  // response register is free now or drains at this edge
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign cmd.take  = req_ready && req_valid;
  assign cmd.load  = (state == S_READ);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### src/bls_dp.sv
module bls_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bls_pkg::ctrl_cmd_t            cmd,
  input  bls_pkg::req_t                 req,
  input  logic                          cfg_we,
  input  logic [bls_pkg::CNT_W-1:0]     cfg_wdata,
  output bls_pkg::rsp_t                 rsp
);
  import bls_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0]   mem [DEPTH];
  logic [WORD_W-1:0]   rd_data;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_next;
  logic [CNT_W-1:0]    capacity;
  logic [CNT_W-1:0]    eff_cap;
  logic [CNT_W-1:0]    rd_idx;
  logic [STATUS_W-1:0] st_next;
  logic                err_next;
  logic                mem_sel_next;
  logic                wr_en;
  logic [STATUS_W-1:0] res_status;
  logic                res_err;
  logic                res_mem_sel;

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = capacity;
    end
  end

  // command decode: status, new fill count, memory access
  always_comb begin
    st_next      = ST_OK;
    err_next     = 1'b0;
    mem_sel_next = 1'b0;
    wr_en        = 1'b0;
    fill_next    = fill;
    rd_idx       = '0;
    case (req.cmd)
      CMD_PUSH: begin
        if (fill >= eff_cap) begin
          st_next  = ST_OVERFLOW;
          err_next = 1'b1;
        end else begin
          wr_en     = 1'b1;
          fill_next = CNT_W'(fill + 1'b1);
        end
      end
      CMD_POP: begin
        if (fill == '0) begin
          st_next  = ST_EMPTY;
          err_next = 1'b1;
        end else begin
          mem_sel_next = 1'b1;
          rd_idx       = CNT_W'(fill - 1'b1);
          fill_next    = CNT_W'(fill - 1'b1);
        end
      end
      CMD_PEEK: begin
        if (req.position == '0 || req.position > fill) begin
          st_next  = ST_BADPOS;
          err_next = 1'b1;
        end else begin
          mem_sel_next = 1'b1;
          rd_idx       = CNT_W'(fill - req.position);
        end
      end
      CMD_TOP: begin
        if (fill == '0) begin
          st_next  = ST_EMPTY;
          err_next = 1'b1;
        end else begin
          mem_sel_next = 1'b1;
          rd_idx       = CNT_W'(fill - 1'b1);
        end
      end
      CMD_BOTTOM: begin
        if (fill == '0) begin
          st_next  = ST_EMPTY;
          err_next = 1'b1;
        end else begin
          mem_sel_next = 1'b1;
          rd_idx       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // entry storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[AW'(fill)] <= req.value;
    end
    if (cmd.take) begin
      rd_data <= mem[AW'(rd_idx)];
    end
  end

  // fill count and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cmd.take) fill <= fill_next;
      if (cfg_we) capacity <= cfg_wdata;
    end
  end

  // decode results held for the read cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_status  <= st_next;
      res_err     <= err_next;
      res_mem_sel <= mem_sel_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (res_err) begin
        rsp.data <= '1;
      end else if (res_mem_sel) begin
        rsp.data <= rd_data;
      end else begin
        rsp.data <= '0;
      end
      rsp.status    <= res_status;
      rsp.count     <= fill;
      rsp.empty_res <= (fill == '0);
      rsp.full_res  <= (fill >= eff_cap);
    end
  end

endmodule

### src/bounded_lifo_stack.sv
// channel    direction  handshake              payload
// req        in         req_valid / req_ready  req (cmd, value, position)
// rsp        out        rsp_valid / rsp_ready  rsp (data, status, count, empty_res, full_res)
// cfg        in         cfg_we                 cfg_wdata (capacity)
//
// each command first updates the fill count and starts the memory read (S_IDLE),
// then captures the registered read data into the response (S_READ).
// a new command is not taken until the previous one has reached the response.
// a stalled response holds the request side off; rst clears the stack to empty
// and sets capacity to 16.
module bounded_lifo_stack (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  bls_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output bls_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [bls_pkg::CNT_W-1:0] cfg_wdata
);
  import bls_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing and handshakes
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // stack storage and result formation
  bls_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule
